// File: hw/rtl/mss_pkg.sv
// ============================================================================
// mss_pkg
// Shared types and constants for the multi-slot soft timer.
// ============================================================================
package mss_pkg;

    localparam int REQ_W    = 2;
    localparam int TICK_W   = 16;
    localparam int USEC_W   = 32;
    localparam int UTAG_W   = 16;
    localparam int SID_W    = 6;
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 5;
    localparam int ERR_W    = 3;
    localparam int RES_W    = 20;
    localparam int PER_W    = 32;
    localparam int DIVD_W   = USEC_W + 4;
    localparam int DCNT_W   = $clog2(DIVD_W + 1);

    localparam logic [RES_W-1:0] RES_RESET = 20'd10000;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int TAG_WIDTH_DEF = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_CLOSE = 2'd2
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_FIRE  = 2'd2,
        KIND_ERR   = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 3'd0,
        ERR_ZERO    = 3'd1,
        ERR_NOFREE  = 3'd2,
        ERR_BELOW   = 3'd3,
        ERR_INVALID = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        OSEL_START = 2'd0,
        OSEL_CLOSE = 2'd1,
        OSEL_ERR   = 2'd2,
        OSEL_FIRE  = 2'd3
    } osel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FULL,
        S_DIVWAIT,
        S_TICK_RD,
        S_TICK_EV,
        S_TICK_END
    } state_t;

    typedef struct packed {
        logic  in_load;
        logic  idx_clr;
        logic  idx_inc;
        logic  mem_rd;
        logic  tick_wr;
        logic  slot_start;
        logic  slot_close;
        logic  pend_load;
        logic  pend_clr;
        logic  out_load;
        osel_t osel;
        err_t  err;
        logic  last;
    } mss_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             usec_zero;
        logic             sid_ok;
        logic             cur_used;
        logic             idx_last;
        logic             fire;
        logic             out_free;
        logic             pend_valid;
        logic             quot_zero;
    } mss_sts_t;

endpackage

// File: hw/rtl/mss_div.sv
// ============================================================================
// mss_div
// Restoring divider, one quotient bit per cycle; done holds until next start.
// ============================================================================
module mss_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mss_pkg::DIVD_W-1:0]   dividend,
    input  logic [mss_pkg::RES_W-1:0]    divisor,
    output logic                         done,
    output logic [mss_pkg::DIVD_W-1:0]   quotient
);
    import mss_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [RES_W-1:0]  dvs_reg;
    logic [RES_W:0]    trial;
    logic              ge;
    logic [RES_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = DCNT_W'(DIVD_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            rem_reg <= ge ? diff[RES_W-1:0] : trial[RES_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/mss_dpath.sv
// ============================================================================
// mss_dpath
// Slot tables, used bits, slot counter, pending fire and output register.
// ============================================================================
module mss_dpath #(
    parameter int NUM_SLOTS = mss_pkg::NUM_SLOTS_DEF,
    parameter int TAG_WIDTH = mss_pkg::TAG_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mss_pkg::RES_W-1:0]   cfg_wr_data,
    input  logic [mss_pkg::REQ_W-1:0]   req_type,
    input  logic [mss_pkg::TICK_W-1:0]  tick_count,
    input  logic [mss_pkg::USEC_W-1:0]  period_usec,
    input  logic [mss_pkg::UTAG_W-1:0]  user_tag,
    input  logic [mss_pkg::SID_W-1:0]   slot_id,
    input  mss_pkg::mss_cmd_t           cmd,
    output mss_pkg::mss_sts_t           sts,
    output logic [mss_pkg::DIVD_W-1:0]  div_dividend,
    output logic [mss_pkg::RES_W-1:0]   div_divisor,
    input  logic [mss_pkg::DIVD_W-1:0]  div_quotient,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mss_pkg::KIND_W-1:0]  resp_kind,
    output logic [mss_pkg::IDX_W-1:0]   slot_index,
    output logic [mss_pkg::UTAG_W-1:0]  fired_tag,
    output logic [mss_pkg::ERR_W-1:0]   error_code,
    output logic                        last
);
    import mss_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [RES_W-1:0]     res_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic [USEC_W-1:0]    usec_reg;
    logic [TAG_WIDTH-1:0] utag_reg;
    logic [SID_W-1:0]     sid_reg;

    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;

    logic [TAG_WIDTH-1:0] tag_mem [0:NUM_SLOTS-1];
    logic [PER_W-1:0]     per_mem [0:NUM_SLOTS-1];
    logic [PER_W-1:0]     ela_mem [0:NUM_SLOTS-1];
    logic [TAG_WIDTH-1:0] rd_tag_reg;
    logic [PER_W-1:0]     rd_per_reg;
    logic [PER_W-1:0]     rd_ela_reg;

    logic                 pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]    pend_idx_reg;
    logic [TAG_WIDTH-1:0] pend_tag_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [UTAG_W-1:0]    out_tag_reg;
    logic [ERR_W-1:0]     out_err_reg;
    logic                 out_last_reg;

    logic [PER_W:0]       ela_sum;
    logic [PER_W-1:0]     ela_sat;
    logic                 fire;
    logic [PER_W-1:0]     per_sat;
    logic [SLOT_W-1:0]    sid_idx;
    logic                 sid_in_range;
    logic                 out_free;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= RES_RESET;
        else if (cfg_wr_en)
            res_reg <= cfg_wr_data;
    end

    assign div_divisor  = (res_reg == '0) ? RES_W'(1) : res_reg;
    assign div_dividend = DIVD_W'({usec_reg, 3'b000}) + DIVD_W'({usec_reg, 1'b0});
    assign per_sat      = (|div_quotient[DIVD_W-1:PER_W]) ? '1 : div_quotient[PER_W-1:0];

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            req_reg  <= req_type;
            tick_reg <= tick_count;
            usec_reg <= period_usec;
            utag_reg <= TAG_WIDTH'(user_tag);
            sid_reg  <= slot_id;
        end
    end

    assign sid_idx      = sid_reg[SLOT_W-1:0];
    assign sid_in_range = {1'b0, sid_reg} < (SID_W+1)'(NUM_SLOTS);

    // tick evaluation on the registered read data
    assign ela_sum = {1'b0, rd_ela_reg} + {{(PER_W+1-TICK_W){1'b0}}, tick_reg};
    assign ela_sat = ela_sum[PER_W] ? '1 : ela_sum[PER_W-1:0];
    assign fire    = ela_sat >= rd_per_reg;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.slot_start)
            used_next[idx_reg] = 1'b1;
        if (cmd.slot_close)
            used_next[sid_idx] = 1'b0;
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (cmd.pend_clr)
            pend_valid_next = 1'b0;
        else if (cmd.pend_load)
            pend_valid_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // slot tables
    always_ff @(posedge clk)
    begin
        if (cmd.slot_start)
        begin
            tag_mem[idx_reg] <= utag_reg;
            per_mem[idx_reg] <= per_sat;
        end
        if (cmd.slot_start || cmd.tick_wr)
            ela_mem[idx_reg] <= cmd.slot_start ? '0 : (fire ? '0 : ela_sat);
        if (cmd.mem_rd)
        begin
            rd_tag_reg <= tag_mem[idx_reg];
            rd_per_reg <= per_mem[idx_reg];
            rd_ela_reg <= ela_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_load)
        begin
            pend_idx_reg <= idx_reg;
            pend_tag_reg <= rd_tag_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.osel)
                OSEL_START:
                begin
                    out_kind_reg <= KIND_START;
                    out_idx_reg  <= IDX_W'(idx_reg);
                    out_tag_reg  <= '0;
                    out_err_reg  <= ERR_NONE;
                    out_last_reg <= 1'b1;
                end
                OSEL_CLOSE:
                begin
                    out_kind_reg <= KIND_CLOSE;
                    out_idx_reg  <= IDX_W'(sid_idx);
                    out_tag_reg  <= '0;
                    out_err_reg  <= ERR_NONE;
                    out_last_reg <= 1'b1;
                end
                OSEL_FIRE:
                begin
                    out_kind_reg <= KIND_FIRE;
                    out_idx_reg  <= IDX_W'(pend_idx_reg);
                    out_tag_reg  <= UTAG_W'(pend_tag_reg);
                    out_err_reg  <= ERR_NONE;
                    out_last_reg <= cmd.last;
                end
                default:
                begin
                    out_kind_reg <= KIND_ERR;
                    out_idx_reg  <= '0;
                    out_tag_reg  <= '0;
                    out_err_reg  <= cmd.err;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign resp_kind  = out_kind_reg;
    assign slot_index = out_idx_reg;
    assign fired_tag  = out_tag_reg;
    assign error_code = out_err_reg;
    assign last       = out_last_reg;

    assign sts.req        = req_reg;
    assign sts.usec_zero  = usec_reg == '0;
    assign sts.sid_ok     = sid_in_range && used_reg[sid_idx];
    assign sts.cur_used   = used_reg[idx_reg];
    assign sts.idx_last   = idx_reg == SLOT_W'(NUM_SLOTS - 1);
    assign sts.fire       = fire;
    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.quot_zero  = div_quotient == '0;

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pend_load && pend_valid_reg) |-> (cmd.out_load && cmd.osel == OSEL_FIRE))
        else $error("pending fire dropped");

    a_start_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.slot_start |-> !used_reg[idx_reg])
        else $error("start on a used slot");

endmodule

// File: hw/rtl/mss_ctrl.sv
// ============================================================================
// mss_ctrl
// Request sequencer: decode, free-slot scan, division wait, tick sweep.
// ============================================================================
module mss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mss_pkg::mss_sts_t  sts,
    input  logic               div_done,
    output logic               div_start,
    output mss_pkg::mss_cmd_t  cmd
);
    import mss_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.osel   = OSEL_ERR;
        cmd.err    = ERR_NONE;
        div_start  = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.req)
                    REQ_TICK:
                    begin
                        cmd.idx_clr  = 1'b1;
                        cmd.pend_clr = 1'b1;
                        state_next   = S_TICK_RD;
                    end
                    REQ_START:
                    begin
                        if (sts.usec_zero)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.osel     = OSEL_ERR;
                                cmd.err      = ERR_ZERO;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            div_start   = 1'b1;
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    REQ_CLOSE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            if (sts.sid_ok)
                            begin
                                cmd.slot_close = 1'b1;
                                cmd.osel       = OSEL_CLOSE;
                            end
                            else
                            begin
                                cmd.osel = OSEL_ERR;
                                cmd.err  = ERR_INVALID;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                if (!sts.cur_used)
                    state_next = S_DIVWAIT;
                else if (sts.idx_last)
                    state_next = S_FULL;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_FULL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.osel     = OSEL_ERR;
                    cmd.err      = ERR_NOFREE;
                    state_next   = S_IDLE;
                end
            end
            S_DIVWAIT:
            begin
                if (div_done && sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.quot_zero)
                    begin
                        cmd.osel = OSEL_ERR;
                        cmd.err  = ERR_BELOW;
                    end
                    else
                    begin
                        cmd.osel       = OSEL_START;
                        cmd.slot_start = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                if (sts.cur_used)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_TICK_EV;
                end
                else if (sts.idx_last)
                    state_next = S_TICK_END;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_TICK_EV:
            begin
                if (!(sts.fire && sts.pend_valid && !sts.out_free))
                begin
                    cmd.tick_wr = 1'b1;
                    if (sts.fire)
                    begin
                        cmd.pend_load = 1'b1;
                        if (sts.pend_valid)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.osel     = OSEL_FIRE;
                            cmd.last     = 1'b0;
                        end
                    end
                    if (sts.idx_last)
                        state_next = S_TICK_END;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TICK_RD;
                    end
                end
            end
            S_TICK_END:
            begin
                if (!sts.pend_valid)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.osel     = OSEL_FIRE;
                    cmd.last     = 1'b1;
                    cmd.pend_clr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/multi_slot_soft_timer.sv
// ============================================================================
// multi_slot_soft_timer
// Table of periodic timer slots advanced by tick requests.
//
//   channel  signals                                   beat
//   in       in_valid/in_ready                         one request
//   out      out_valid/out_ready                       one response
//   cfg      cfg_wr_en/cfg_wr_data                     base_resolution write
//
// One request at a time; input accepted only in the idle state, while the
// previous response may still sit in the output register.
// Tick: sequential slot sweep over single-port slot tables; each used slot
// is read (S_TICK_RD), then evaluated (S_TICK_EV); free slots are skipped.
// Start: the free-slot scan runs while the bit-serial divider works, and
// the response waits for the quotient, as does a below-resolution error;
// a full table is reported when the scan ends. Close requests and
// zero-period errors answer from decode. Output stalls hold the sequencer.
// Reset clears used bits and control; slot tables need no clearing.
// ============================================================================
module multi_slot_soft_timer #(
    parameter int NUM_SLOTS = mss_pkg::NUM_SLOTS_DEF,
    parameter int TAG_WIDTH = mss_pkg::TAG_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mss_pkg::RES_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mss_pkg::REQ_W-1:0]   req_type,
    input  logic [mss_pkg::TICK_W-1:0]  tick_count,
    input  logic [mss_pkg::USEC_W-1:0]  period_usec,
    input  logic [mss_pkg::UTAG_W-1:0]  user_tag,
    input  logic [mss_pkg::SID_W-1:0]   slot_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mss_pkg::KIND_W-1:0]  resp_kind,
    output logic [mss_pkg::IDX_W-1:0]   slot_index,
    output logic [mss_pkg::UTAG_W-1:0]  fired_tag,
    output logic [mss_pkg::ERR_W-1:0]   error_code,
    output logic                        last
);
    import mss_pkg::*;

    mss_cmd_t          cmd;
    mss_sts_t          sts;
    logic              div_start;
    logic              div_done;
    logic [DIVD_W-1:0] div_dividend;
    logic [RES_W-1:0]  div_divisor;
    logic [DIVD_W-1:0] div_quotient;

    mss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sts       (sts),
        .div_done  (div_done),
        .div_start (div_start),
        .cmd       (cmd)
    );

    mss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    mss_dpath #(
        .NUM_SLOTS (NUM_SLOTS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_type     (req_type),
        .tick_count   (tick_count),
        .period_usec  (period_usec),
        .user_tag     (user_tag),
        .slot_id      (slot_id),
        .cmd          (cmd),
        .sts          (sts),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quotient (div_quotient),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .resp_kind    (resp_kind),
        .slot_index   (slot_index),
        .fired_tag    (fired_tag),
        .error_code   (error_code),
        .last         (last)
    );

endmodule
